@@ sv/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ sv/saedt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package saedt_pkg;
	localparam int unsigned TableEntries = 16;
	localparam logic [7:0] FlagsSyn = 8'd2;
	localparam logic [7:0] FlagsSynAck = 8'd18;
	localparam logic [15:0] HoldReset = 16'd300;

	typedef enum logic [1:0] {
		OP_PASS,
		OP_RECORD,
		OP_SCAN
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] now_ms;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} bstate_t;
endpackage
`default_nettype wire

@@ sv/syn_ack_early_drop_tracker.sv @@
// SYN to SYN/ACK early-drop tracker.
// Input channel: in_valid/in_stall with one packet summary per transfer.
// Output channel: out_valid/out_stall, one verdict per packet, in order:
// forward_packet, recorded, table_full.
// Config: cfg_we/cfg_wdata write min_hold_ms (reset 300); write while idle.
// A two-entry queue decouples intake from the table engine.
// Flow: each packet passes through the queue, then the table engine,
// which shows its verdict in ST_DONE; a SYN/ACK first walks all
// TABLE_ENTRIES slots in ST_SCAN, one per cycle. The engine takes a new
// packet only from ST_IDLE, after the last verdict has left ST_DONE.
// Reset clears all slot valid bits and the queue; the verdict is held
// while out_stall is high, and the queue fills then stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module syn_ack_early_drop_tracker #(
	parameter int unsigned TABLE_ENTRIES = saedt_pkg::TableEntries
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        outgoing,
	input  wire logic        is_tcp,
	input  wire logic [7:0]  tcp_flag_bits,
	input  wire logic [31:0] source_ip,
	input  wire logic [31:0] dest_ip,
	input  wire logic [15:0] source_port,
	input  wire logic [15:0] dest_port,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             forward_packet,
	output logic             recorded,
	output logic             table_full
);
	import saedt_pkg::*;

	logic [15:0] hold_q;
	logic cmd_valid, cmd_take;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HoldReset;
		end else if (cfg_we) begin
			hold_q <= cfg_wdata;
		end
	end

	saedt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.outgoing(outgoing), .is_tcp(is_tcp), .tcp_flag_bits(tcp_flag_bits),
		.source_ip(source_ip), .dest_ip(dest_ip), .source_port(source_port),
		.dest_port(dest_port), .now_ms(now_ms),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	saedt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .min_hold_ms(hold_q),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
		.out_valid(out_valid), .out_stall(out_stall),
		.forward_packet(forward_packet), .recorded(recorded), .table_full(table_full)
	);
endmodule
`default_nettype wire

@@ sv/saedt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module saedt_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           outgoing,
	input  wire logic           is_tcp,
	input  wire logic [7:0]     tcp_flag_bits,
	input  wire logic [31:0]    source_ip,
	input  wire logic [31:0]    dest_ip,
	input  wire logic [15:0]    source_port,
	input  wire logic [15:0]    dest_port,
	input  wire logic [31:0]    now_ms,
	output logic                cmd_valid,
	output saedt_pkg::cmd_t     cmd,
	input  wire logic           cmd_take
);
	import saedt_pkg::*;

	// two-entry queue
	cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic wr_ptr_q, rd_ptr_q;
	cmd_t c;
	logic push, pop;

	always_comb begin
		c.source_ip = source_ip;
		c.dest_ip = dest_ip;
		c.source_port = source_port;
		c.dest_port = dest_port;
		c.now_ms = now_ms;
		if (is_tcp && outgoing && tcp_flag_bits == FlagsSyn) begin
			c.op = OP_RECORD;
		end else if (is_tcp && !outgoing && tcp_flag_bits == FlagsSynAck) begin
			c.op = OP_SCAN;
		end else begin
			c.op = OP_PASS;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_ptr_q];
	assign pop = cmd_valid && cmd_take;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

@@ sv/saedt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module saedt_back #(
	parameter int unsigned TABLE_ENTRIES = saedt_pkg::TableEntries
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [15:0]    min_hold_ms,
	input  wire logic           cmd_valid,
	input  wire saedt_pkg::cmd_t cmd,
	output logic                cmd_take,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic                forward_packet,
	output logic                recorded,
	output logic                table_full
);
	import saedt_pkg::*;
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] rip_q [TABLE_ENTRIES];
	logic [31:0] lip_q [TABLE_ENTRIES];
	logic [15:0] rpt_q [TABLE_ENTRIES];
	logic [15:0] lpt_q [TABLE_ENTRIES];
	logic [31:0] st_q [TABLE_ENTRIES];

	bstate_t state_q, state_d;
	cmd_t cur_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] ix;
	logic [31:0] age;
	logic young, hit, free_found;
	logic [IW-1:0] free_ix;

	assign ix = idx_q[IW-1:0];
	assign age = cur_q.now_ms - st_q[ix];
	assign young = age < {16'd0, min_hold_ms};
	assign hit = young && rip_q[ix] == cur_q.source_ip && rpt_q[ix] == cur_q.source_port
		&& lip_q[ix] == cur_q.dest_ip && lpt_q[ix] == cur_q.dest_port;

	always_comb begin
		free_found = 1'b0;
		free_ix = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_ix = IW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_valid) state_d = (cmd.op == OP_SCAN) ? ST_SCAN : ST_DONE;
			ST_SCAN: if (idx_q == CW'(TABLE_ENTRIES - 1)) state_d = ST_DONE;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_take = (state_q == ST_IDLE);
		out_valid = (state_q == ST_DONE);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cur_q <= cmd;
			if (cmd.op == OP_RECORD && free_found) begin
				rip_q[free_ix] <= cmd.dest_ip;
				lip_q[free_ix] <= cmd.source_ip;
				rpt_q[free_ix] <= cmd.dest_port;
				lpt_q[free_ix] <= cmd.source_port;
				st_q[free_ix] <= cmd.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			idx_q <= '0;
			forward_packet <= 1'b1;
			recorded <= 1'b0;
			table_full <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && cmd_valid) begin
				idx_q <= '0;
				forward_packet <= 1'b1;
				recorded <= (cmd.op == OP_RECORD) && free_found;
				table_full <= (cmd.op == OP_RECORD) && !free_found;
				if (cmd.op == OP_RECORD && free_found) valid_q[free_ix] <= 1'b1;
			end
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + 1'b1;
				if (valid_q[ix]) begin
					if (hit) begin
						forward_packet <= 1'b0;
					end
					if (!young) valid_q[ix] <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/saedt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module saedt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic forward_packet,
	input wire logic recorded,
	input wire logic table_full
);
	`CHK_IMPL(a_rec_full, clk, arst_n, out_valid, !(recorded && table_full), "rec and full")
	`CHK_IMPL(a_drop_clean, clk, arst_n, out_valid && !forward_packet, !recorded && !table_full, "drop flags")
	`CHK_IMPL(a_rec_fwd, clk, arst_n, out_valid && (recorded || table_full), forward_packet, "syn dropped")
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(forward_packet), "held")
endmodule
bind syn_ack_early_drop_tracker saedt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.forward_packet(forward_packet), .recorded(recorded), .table_full(table_full)
);
`default_nettype wire
